// File: sv/tcg_pkg.sv
// Shared types, constants and functions of the texture coordinate generator.
// No dependencies; tcg_core, the top level and the testbench import this package.
package tcg_pkg;

  // Default number of fraction bits in the fixed-point formats
  localparam int TCG_FRAC_BITS = 16;
  localparam int CORDIC_STEPS  = 24;
  localparam int ADDR_W        = 6;

  // Mode codes
  localparam logic [3:0] MODE_ENV_INF   = 4'd0;
  localparam logic [3:0] MODE_ENV_LOCAL = 4'd1;
  localparam logic [3:0] MODE_GEOM_X    = 4'd2;
  localparam logic [3:0] MODE_GEOM_Y    = 4'd3;
  localparam logic [3:0] MODE_GEOM_Z    = 4'd4;
  localparam logic [3:0] MODE_MAP       = 4'd5;
  localparam logic [3:0] MODE_SCALE     = 4'd6;
  localparam logic [3:0] MODE_SCALE_OFS = 4'd7;
  localparam logic [3:0] MODE_COPY      = 4'd8;
  localparam logic [3:0] MODE_SHIFT     = 4'd9;

  // Register indexes (byte address = 8 * index)
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_UW     = 3'd1;
  localparam logic [2:0] REG_VW     = 3'd2;
  localparam logic [2:0] REG_UVOFS  = 3'd3;
  localparam logic [2:0] REG_EYE_XY = 3'd4;
  localparam logic [2:0] REG_EYE_Z  = 3'd5;
  localparam logic [2:0] REG_SHIFT  = 3'd6;

  // Configuration handed from the register file to the datapath
  typedef struct packed {
    logic [3:0]  mode;
    logic [63:0] u_weights;
    logic [63:0] v_weights;
    logic [63:0] uv_offsets;
    logic [63:0] eye_xy;
    logic [31:0] eye_z;
    logic [9:0]  shift_amounts;
  } cfg_t;

  // Fold unused mode codes onto map affine
  function automatic logic [3:0] eff_mode(logic [3:0] m);
    logic [3:0] r;
    r = (m > MODE_SHIFT) ? MODE_MAP : m;
    return r;
  endfunction

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(int i);
    logic [31:0] t;
    case (i)
      0:       t = 32'd536870912;
      1:       t = 32'd316933406;
      2:       t = 32'd167458907;
      3:       t = 32'd85004756;
      4:       t = 32'd42667331;
      5:       t = 32'd21354465;
      6:       t = 32'd10679838;
      7:       t = 32'd5340245;
      8:       t = 32'd2670163;
      9:       t = 32'd1335087;
      10:      t = 32'd667544;
      11:      t = 32'd333772;
      12:      t = 32'd166886;
      13:      t = 32'd83443;
      14:      t = 32'd41722;
      15:      t = 32'd20861;
      16:      t = 32'd10430;
      17:      t = 32'd5215;
      18:      t = 32'd2608;
      19:      t = 32'd1304;
      20:      t = 32'd652;
      21:      t = 32'd326;
      22:      t = 32'd163;
      23:      t = 32'd81;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

  // Full signed 32 x 32 product
  function automatic logic [63:0] smul(logic [31:0] a, logic [31:0] b);
    logic signed [63:0] ax;
    logic signed [63:0] bx;
    ax = $signed({{32{a[31]}}, a});
    bx = $signed({{32{b[31]}}, b});
    return 64'(ax * bx);
  endfunction

endpackage

// File: sv/tcg_in_if.sv
// Vertex input channel: valid/ready handshake with position, normal and map fields.
// No dependencies.
interface tcg_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] normal_x;
  logic [31:0] normal_y;
  logic [31:0] normal_z;
  logic [31:0] map_u;
  logic [31:0] map_v;

  modport source (output valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                  map_u, map_v, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                  map_u, map_v, output ready);
endinterface

// File: sv/tcg_out_if.sv
// Texture coordinate output channel: valid/ready handshake with tex_u, tex_v.
// No dependencies.
interface tcg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] tex_u;
  logic [31:0] tex_v;

  modport source (output valid, tex_u, tex_v, input ready);
  modport sink   (input valid, tex_u, tex_v, output ready);
endinterface

// File: sv/tcg_core.sv
// Pipelined texture coordinate datapath: eye normalization, reflection, CORDIC, affine, scale, copy, shift.
// Depends on tcg_pkg, tcg_in_if and tcg_out_if.
module tcg_core
  import tcg_pkg::*;
#(
  parameter int FRAC_BITS = TCG_FRAC_BITS
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  tcg_in_if.sink   vtx,
  tcg_out_if.source tex
);

  localparam int DQW      = 32 + FRAC_BITS;
  localparam int CW       = 36;
  localparam int S_SQ     = 1;
  localparam int S_SUM    = 2;
  localparam int S_SQRT0  = 3;
  localparam int S_DIV0   = S_SQRT0 + 32;
  localparam int S_ESEL   = S_DIV0 + DQW;
  localparam int S_DOTP   = S_ESEL + 1;
  localparam int S_DOT    = S_ESEL + 2;
  localparam int S_RP     = S_ESEL + 3;
  localparam int S_R      = S_ESEL + 4;
  localparam int S_CI     = S_ESEL + 5;
  localparam int S_COR0   = S_ESEL + 6;
  localparam int S_CF     = S_COR0 + CORDIC_STEPS;
  localparam int S_MUL    = S_CF + 1;
  localparam int S_OUT    = S_CF + 2;
  localparam int NST      = S_OUT + 1;

  typedef struct packed {
    logic [3:0]           mode;
    logic [2:0][31:0]     pos;
    logic [2:0][31:0]     nrm;
    logic [31:0]          mu;
    logic [31:0]          mv;
    logic [2:0][31:0]     dif;
    logic [65:0]          srem;
    logic [31:0]          root;
    logic [2:0][31:0]     drem;
    logic [2:0][DQW-1:0]  quo;
    logic [2:0][31:0]     e;
    logic [3:0][63:0]     prd;
    logic [31:0]          dd;
    logic [2:0][31:0]     r;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic [31:0]          ang;
    logic                 zero;
    logic [31:0]          s0;
    logic [31:0]          s1;
  } pipe_t;

  pipe_t st [NST];
  pipe_t nx [NST];
  logic  vld [NST];
  logic  adv;

  // Take the fixed-point bits of a wide product or sum
  function automatic logic [31:0] fin(logic [63:0] acc);
    return acc[FRAC_BITS +: 32];
  endfunction

  // Whole pipeline advances unless the output register holds an untaken transaction
  assign adv       = !vld[NST-1] || tex.ready;
  assign vtx.ready = adv;
  assign tex.valid = vld[NST-1];
  assign tex.tex_u = st[NST-1].s0;
  assign tex.tex_v = st[NST-1].s1;

  // Capture the vertex
  always_comb begin
    nx[0]      = '0;
    nx[0].mode = eff_mode(cfg.mode);
    nx[0].pos  = {vtx.pos_z, vtx.pos_y, vtx.pos_x};
    nx[0].nrm  = {vtx.normal_z, vtx.normal_y, vtx.normal_x};
    nx[0].mu   = vtx.map_u;
    nx[0].mv   = vtx.map_v;
  end

  // Eye minus vertex and its squares
  always_comb begin
    nx[S_SQ] = st[S_SQ-1];
    nx[S_SQ].dif[0] = cfg.eye_xy[31:0]  - st[S_SQ-1].pos[0];
    nx[S_SQ].dif[1] = cfg.eye_xy[63:32] - st[S_SQ-1].pos[1];
    nx[S_SQ].dif[2] = cfg.eye_z         - st[S_SQ-1].pos[2];
    for (int j = 0; j < 3; j++) begin
      nx[S_SQ].prd[j] = smul(nx[S_SQ].dif[j], nx[S_SQ].dif[j]);
    end
  end

  // Sum of squares, wrapping at 64 bits; seed the root and divider
  always_comb begin
    nx[S_SUM] = st[S_SUM-1];
    nx[S_SUM].srem = {2'b00, st[S_SUM-1].prd[0] + st[S_SUM-1].prd[1] + st[S_SUM-1].prd[2]};
    nx[S_SUM].root = '0;
    nx[S_SUM].drem = '0;
    nx[S_SUM].quo  = '0;
  end

  // Square root, one result bit per stage from the top
  for (genvar g = 0; g < 32; g++) begin : g_sqrt
    localparam int B = 31 - g;
    localparam int K = S_SQRT0 + g;
    logic [65:0] cand;
    always_comb begin
      cand  = (66'(st[K-1].root) << (B + 1)) + (66'(1) << (2 * B));
      nx[K] = st[K-1];
      if (st[K-1].srem >= cand) begin
        nx[K].srem    = st[K-1].srem - cand;
        nx[K].root[B] = 1'b1;
      end
    end
  end

  // Restoring division of each scaled eye component by the length
  for (genvar g = 0; g < DQW; g++) begin : g_div
    localparam int J = DQW - 1 - g;
    localparam int K = S_DIV0 + g;
    logic [2:0][31:0]    mg;
    logic [2:0][DQW-1:0] mw;
    logic [2:0][32:0]    r2;
    always_comb begin
      nx[K] = st[K-1];
      for (int j = 0; j < 3; j++) begin
        mg[j] = st[K-1].dif[j][31] ? 32'(32'd0 - st[K-1].dif[j]) : st[K-1].dif[j];
        mw[j] = {mg[j], {FRAC_BITS{1'b0}}};
        r2[j] = {st[K-1].drem[j], mw[j][J]};
        if (r2[j] >= {1'b0, st[K-1].root}) begin
          nx[K].drem[j]   = 32'(r2[j] - {1'b0, st[K-1].root});
          nx[K].quo[j][J] = 1'b1;
        end else begin
          nx[K].drem[j] = r2[j][31:0];
        end
      end
    end
  end

  // Select the eye vector: configured direction or normalized local eye
  always_comb begin
    nx[S_ESEL] = st[S_ESEL-1];
    if (st[S_ESEL-1].mode == MODE_ENV_LOCAL) begin
      for (int j = 0; j < 3; j++) begin
        if (st[S_ESEL-1].root == '0) begin
          nx[S_ESEL].e[j] = '0;
        end else if (st[S_ESEL-1].dif[j][31]) begin
          nx[S_ESEL].e[j] = 32'd0 - st[S_ESEL-1].quo[j][31:0];
        end else begin
          nx[S_ESEL].e[j] = st[S_ESEL-1].quo[j][31:0];
        end
      end
    end else begin
      nx[S_ESEL].e = {cfg.eye_z, cfg.eye_xy[63:32], cfg.eye_xy[31:0]};
    end
  end

  // N.E products
  always_comb begin
    nx[S_DOTP] = st[S_DOTP-1];
    for (int j = 0; j < 3; j++) begin
      nx[S_DOTP].prd[j] = smul(st[S_DOTP-1].nrm[j], st[S_DOTP-1].e[j]);
    end
  end

  // d = 2 * dot(N, E)
  always_comb begin
    nx[S_DOT]    = st[S_DOT-1];
    nx[S_DOT].dd = fin(st[S_DOT-1].prd[0] + st[S_DOT-1].prd[1] + st[S_DOT-1].prd[2]) << 1;
  end

  // N * d products
  always_comb begin
    nx[S_RP] = st[S_RP-1];
    for (int j = 0; j < 3; j++) begin
      nx[S_RP].prd[j] = smul(st[S_RP-1].nrm[j], st[S_RP-1].dd);
    end
  end

  // R = N * d - E
  always_comb begin
    nx[S_R] = st[S_R-1];
    for (int j = 0; j < 3; j++) begin
      nx[S_R].r[j] = fin(st[S_R-1].prd[j]) - st[S_R-1].e[j];
    end
  end

  // CORDIC entry: x = -Rz, y = Rx, fold the left half-plane
  logic [31:0] ci_x;
  always_comb begin
    nx[S_CI]      = st[S_CI-1];
    ci_x          = 32'd0 - st[S_CI-1].r[2];
    nx[S_CI].zero = (ci_x == '0) && (st[S_CI-1].r[0] == '0);
    if (ci_x[31]) begin
      nx[S_CI].cx  = -CW'($signed(ci_x));
      nx[S_CI].cy  = -CW'($signed(st[S_CI-1].r[0]));
      nx[S_CI].ang = 32'h8000_0000;
    end else begin
      nx[S_CI].cx  = CW'($signed(ci_x));
      nx[S_CI].cy  = CW'($signed(st[S_CI-1].r[0]));
      nx[S_CI].ang = '0;
    end
  end

  // CORDIC vectoring, one micro-rotation per stage
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cor
    localparam int K = S_COR0 + g;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    always_comb begin
      nx[K] = st[K-1];
      xs    = st[K-1].cx >>> g;
      ys    = st[K-1].cy >>> g;
      if (st[K-1].cy > 0) begin
        nx[K].cx  = st[K-1].cx + ys;
        nx[K].cy  = st[K-1].cy - xs;
        nx[K].ang = st[K-1].ang + atan_turn(g);
      end else begin
        nx[K].cx  = st[K-1].cx - ys;
        nx[K].cy  = st[K-1].cy + xs;
        nx[K].ang = st[K-1].ang - atan_turn(g);
      end
    end
  end

  // Pick the two sources for the mode
  logic [31:0]        cf_ang;
  logic signed [32:0] cf_neg;
  logic signed [32:0] cf_half;
  always_comb begin
    nx[S_CF] = st[S_CF-1];
    cf_ang   = st[S_CF-1].ang + (32'd1 << (31 - FRAC_BITS));
    cf_neg   = 33'($signed(32'd0 - st[S_CF-1].r[1]));
    cf_half  = (cf_neg + 33'(cf_neg < 0)) >>> 1;
    case (st[S_CF-1].mode)
      MODE_ENV_INF, MODE_ENV_LOCAL: begin
        nx[S_CF].s0 = st[S_CF-1].zero ? 32'd0 : (cf_ang >> (32 - FRAC_BITS));
        nx[S_CF].s1 = cf_half[31:0] + (32'd1 << (FRAC_BITS - 1));
      end
      MODE_GEOM_X: begin
        nx[S_CF].s0 = st[S_CF-1].pos[1];
        nx[S_CF].s1 = st[S_CF-1].pos[2];
      end
      MODE_GEOM_Y: begin
        nx[S_CF].s0 = st[S_CF-1].pos[2];
        nx[S_CF].s1 = st[S_CF-1].pos[0];
      end
      MODE_GEOM_Z: begin
        nx[S_CF].s0 = st[S_CF-1].pos[0];
        nx[S_CF].s1 = st[S_CF-1].pos[1];
      end
      default: begin
        nx[S_CF].s0 = st[S_CF-1].mu;
        nx[S_CF].s1 = st[S_CF-1].mv;
      end
    endcase
  end

  // Weight products
  always_comb begin
    nx[S_MUL] = st[S_MUL-1];
    nx[S_MUL].prd[0] = smul(cfg.u_weights[31:0],  st[S_MUL-1].s0);
    nx[S_MUL].prd[1] = smul(cfg.u_weights[63:32], st[S_MUL-1].s1);
    nx[S_MUL].prd[2] = smul(cfg.v_weights[31:0],  st[S_MUL-1].s0);
    nx[S_MUL].prd[3] = smul(cfg.v_weights[63:32], st[S_MUL-1].s1);
  end

  // Final combine per mode into the output register
  pipe_t fo;
  always_comb begin
    fo        = st[S_OUT-1];
    nx[S_OUT] = fo;
    case (fo.mode)
      MODE_SCALE: begin
        nx[S_OUT].s0 = fin(fo.prd[0]);
        nx[S_OUT].s1 = fin(fo.prd[3]);
      end
      MODE_SCALE_OFS: begin
        nx[S_OUT].s0 = fin(fo.prd[0]) + cfg.uv_offsets[31:0];
        nx[S_OUT].s1 = fin(fo.prd[3]) + cfg.uv_offsets[63:32];
      end
      MODE_COPY: begin
        nx[S_OUT].s0 = fo.mu;
        nx[S_OUT].s1 = fo.mv;
      end
      MODE_SHIFT: begin
        nx[S_OUT].s0 = (fo.mu << cfg.shift_amounts[4:0]) + cfg.uv_offsets[31:0];
        nx[S_OUT].s1 = (fo.mv << cfg.shift_amounts[9:5]) + cfg.uv_offsets[63:32];
      end
      default: begin
        nx[S_OUT].s0 = fin(fo.prd[0] + fo.prd[1]) + cfg.uv_offsets[31:0];
        nx[S_OUT].s1 = fin(fo.prd[2] + fo.prd[3]) + cfg.uv_offsets[63:32];
      end
    endcase
  end

  // Advance payload
  for (genvar k = 0; k < NST; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (adv) st[k] <= nx[k];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NST; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= vtx.valid;
      for (int k = 1; k < NST; k++) vld[k] <= vld[k-1];
    end
  end

  // A waiting result stalls the input side
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (tex.valid && !tex.ready) |-> !vtx.ready)
    else $error("input accepted while output stalled");

  // An accepted vertex enters the first stage
  a_valid_moves: assert property (@(posedge clk) disable iff (rst)
    (adv && vtx.valid) |=> vld[0])
    else $error("accepted vertex lost at pipeline entry");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!vld[NST-1] && !vld[0]))
    else $error("pipeline not empty after reset");

endmodule

// File: sv/texture_coordinate_generator_top.sv
// Top level: APB configuration registers around the texture coordinate pipeline.
// Depends on tcg_pkg, tcg_in_if, tcg_out_if and tcg_core.
//
// While no result waits at the output, one vertex enters per cycle and one (tex_u,
// tex_v) pair leaves per cycle. Every mode passes through the same stages; the
// depth is set by the 32-stage square root and the (32 + FRAC_BITS)-stage divider
// that normalize the local eye vector, and by the 24-stage CORDIC that turns the
// reflection vector into u. The whole pipeline holds while a result waits at the
// output. Registers sit at byte address 8 * index and are to be written only
// while the pipeline is empty; the user keeps to this, the block does not enforce it.
module texture_coordinate_generator_top
  import tcg_pkg::*;
#(
  parameter int FRAC_BITS = TCG_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  tcg_in_if.sink            vtx,
  tcg_out_if.source         tex,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  cfg_t        cfg;
  logic        wr_en;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:3];

  // Write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode          <= MODE_MAP;
      cfg.u_weights     <= 64'd1 << FRAC_BITS;
      cfg.v_weights     <= 64'd1 << (32 + FRAC_BITS);
      cfg.uv_offsets    <= '0;
      cfg.eye_xy        <= '0;
      cfg.eye_z         <= 32'd1 << FRAC_BITS;
      cfg.shift_amounts <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_MODE:   cfg.mode          <= pwdata[3:0];
        REG_UW:     cfg.u_weights     <= pwdata;
        REG_VW:     cfg.v_weights     <= pwdata;
        REG_UVOFS:  cfg.uv_offsets    <= pwdata;
        REG_EYE_XY: cfg.eye_xy        <= pwdata;
        REG_EYE_Z:  cfg.eye_z         <= pwdata[31:0];
        REG_SHIFT:  cfg.shift_amounts <= pwdata[9:0];
        default:    ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_MODE:   prdata = {60'd0, cfg.mode};
      REG_UW:     prdata = cfg.u_weights;
      REG_VW:     prdata = cfg.v_weights;
      REG_UVOFS:  prdata = cfg.uv_offsets;
      REG_EYE_XY: prdata = cfg.eye_xy;
      REG_EYE_Z:  prdata = {32'd0, cfg.eye_z};
      REG_SHIFT:  prdata = {54'd0, cfg.shift_amounts};
      default:    prdata = '0;
    endcase
  end

  tcg_core #(.FRAC_BITS(FRAC_BITS)) u_core (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .vtx (vtx),
    .tex (tex)
  );

endmodule

// File: test/tb_top.sv
// Self-checking testbench for texture_coordinate_generator_top: vertex stream in,
// texture pairs out, checked against a cycle-free fixed-point predictor.
// Depends on tcg_pkg, tcg_in_if, tcg_out_if and the RTL under sv/.
module tb_top;
  import tcg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB           = TCG_FRAC_BITS;
  localparam int DRAIN_CYCLES = 99 + FB + 20;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 400;

  // Arctangent steps in units of 2^-32 turn
  localparam logic [31:0] ATAN_STEP [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81};

  typedef struct packed {
    logic [31:0] px, py, pz, nx, ny, nz, mu, mv;
  } vertex_t;

  typedef struct packed {
    logic [31:0] u, v;
  } tex_pair_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  tcg_in_if  vtx_bus ();
  tcg_out_if tex_bus ();

  texture_coordinate_generator_top dut (
    .clk(clk), .rst(rst), .vtx(vtx_bus), .tex(tex_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the configuration registers
  logic [3:0]  cfg_mode = MODE_MAP;
  logic [63:0] cfg_uw   = 64'd1 << FB;
  logic [63:0] cfg_vw   = 64'd1 << (32 + FB);
  logic [63:0] cfg_ofs  = '0;
  logic [63:0] cfg_exy  = '0;
  logic [31:0] cfg_ez   = 32'd1 << FB;
  logic [9:0]  cfg_sh   = '0;

  tex_pair_t pending_tex[$];
  int        error_count = 0;
  int        idle_cycles = 0;
  bit        steady_send = 1'b0;
  bit        steady_recv = 1'b0;
  int        hold_token  = 0;
  int        hold_seen   = 0;
  int        hold_left   = 0;
  int        stall_left  = 0;

  initial begin
    vtx_bus.valid = 1'b0;
    {vtx_bus.pos_x, vtx_bus.pos_y, vtx_bus.pos_z} = '0;
    {vtx_bus.normal_x, vtx_bus.normal_y, vtx_bus.normal_z} = '0;
    {vtx_bus.map_u, vtx_bus.map_v} = '0;
    tex_bus.ready = 1'b0;
  end

  // ---------------- fixed-point predictor ----------------

  function automatic logic signed [63:0] sext(logic [31:0] a);
    return {{32{a[31]}}, a};
  endfunction

  function automatic logic [63:0] full_prod(logic [31:0] a, logic [31:0] b);
    return 64'(sext(a) * sext(b));
  endfunction

  function automatic logic [31:0] scale_down(logic [63:0] acc);
    return acc[FB +: 32];
  endfunction

  function automatic logic [31:0] reflect_turn(logic [31:0] y32, logic [31:0] x32);
    logic signed [63:0] x, y, nx;
    logic [31:0] ang;
    x = sext(x32);
    y = sext(y32);
    ang = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = 32'h8000_0000;
    end
    for (int i = 0; i < 24; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        ang += ATAN_STEP[i];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        ang -= ATAN_STEP[i];
      end
      x = nx;
    end
    ang += 32'd1 << (31 - FB);
    return ang >> (32 - FB);
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] val);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > val) b >>= 2;
    while (b != 0) begin
      if (val >= r + b) begin
        val -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] unit_comp(logic signed [63:0] d, logic [63:0] len);
    logic [63:0] mag, q;
    mag = 64'(d < 0 ? -d : d) << FB;
    q = mag / len;
    return (d < 0) ? 32'(-q) : q[31:0];
  endfunction

  // Reflect the eye about the normal and map R onto (s0, s1)
  function automatic void env_coords(logic [31:0] e [3], vertex_t vx,
                                     output logic [31:0] s0, output logic [31:0] s1);
    logic [31:0] dot2, rx, ry, rz;
    logic signed [63:0] neg;
    dot2 = scale_down(full_prod(vx.nx, e[0]) + full_prod(vx.ny, e[1]) +
                      full_prod(vx.nz, e[2])) << 1;
    rx = scale_down(full_prod(vx.nx, dot2)) - e[0];
    ry = scale_down(full_prod(vx.ny, dot2)) - e[1];
    rz = scale_down(full_prod(vx.nz, dot2)) - e[2];
    neg = sext(-ry);
    s0 = reflect_turn(rx, -rz);
    s1 = 32'(neg / 2) + (32'd1 << (FB - 1));
  endfunction

  function automatic tex_pair_t gen_tex_coords(vertex_t vx);
    logic [31:0] s0, s1, w00, w10, w01, w11, ou, ov;
    logic [31:0] e [3];
    logic signed [63:0] d0, d1, d2;
    logic [63:0] len;
    tex_pair_t t;
    bit affine;
    {w10, w00} = cfg_uw;
    {w11, w01} = cfg_vw;
    {ov, ou} = cfg_ofs;
    s0 = vx.mu;
    s1 = vx.mv;
    affine = 1'b1;
    t = '0;
    case (cfg_mode)
      MODE_ENV_INF: begin
        e[0] = cfg_exy[31:0];
        e[1] = cfg_exy[63:32];
        e[2] = cfg_ez;
        env_coords(e, vx, s0, s1);
      end
      MODE_ENV_LOCAL: begin
        d0 = sext(cfg_exy[31:0] - vx.px);
        d1 = sext(cfg_exy[63:32] - vx.py);
        d2 = sext(cfg_ez - vx.pz);
        len = root_floor(64'(d0 * d0) + 64'(d1 * d1) + 64'(d2 * d2));
        if (len == 0) begin
          e[0] = '0; e[1] = '0; e[2] = '0;
        end else begin
          e[0] = unit_comp(d0, len);
          e[1] = unit_comp(d1, len);
          e[2] = unit_comp(d2, len);
        end
        env_coords(e, vx, s0, s1);
      end
      MODE_GEOM_X: begin s0 = vx.py; s1 = vx.pz; end
      MODE_GEOM_Y: begin s0 = vx.pz; s1 = vx.px; end
      MODE_GEOM_Z: begin s0 = vx.px; s1 = vx.py; end
      MODE_SCALE, MODE_SCALE_OFS: begin
        affine = 1'b0;
        t.u = scale_down(full_prod(w00, vx.mu));
        t.v = scale_down(full_prod(w11, vx.mv));
        if (cfg_mode == MODE_SCALE_OFS) begin
          t.u += ou;
          t.v += ov;
        end
      end
      MODE_COPY: begin
        affine = 1'b0;
        t.u = vx.mu;
        t.v = vx.mv;
      end
      MODE_SHIFT: begin
        affine = 1'b0;
        t.u = (vx.mu << cfg_sh[4:0]) + ou;
        t.v = (vx.mv << cfg_sh[9:5]) + ov;
      end
      default: ;
    endcase
    if (affine) begin
      t.u = scale_down(full_prod(w00, s0) + full_prod(w10, s1)) + ou;
      t.v = scale_down(full_prod(w01, s0) + full_prod(w11, s1)) + ov;
    end
    return t;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 262143)) - 32'd131072;
      1: case ($urandom_range(0, 5))
           0: return 32'h0000_0000;
           1: return 32'h7fff_ffff;
           2: return 32'h8000_0000;
           3: return 32'hffff_ffff;
           4: return 32'd1 << FB;
           default: return 32'd1;
         endcase
      default: return $urandom;
    endcase
  endfunction

  // Mostly unit-scale normals so the reflection stays in a sensible range
  function automatic logic [31:0] pick_normal();
    if ($urandom_range(0, 3) == 0) return pick_word();
    return 32'($urandom_range(0, 131072)) - 32'd65536;
  endfunction

  function automatic vertex_t pick_vertex();
    vertex_t vx;
    vx.px = pick_word(); vx.py = pick_word(); vx.pz = pick_word();
    vx.nx = pick_normal(); vx.ny = pick_normal(); vx.nz = pick_normal();
    vx.mu = pick_word(); vx.mv = pick_word();
    return vx;
  endfunction

  function automatic logic [63:0] pick_reg64();
    return {pick_word(), pick_word()};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one vertex and hold it until the transaction completes
  task automatic send_vertex(vertex_t vx);
    int gap;
    gap = steady_send ? 0 : pick_gap();
    if (gap > 0) begin
      vtx_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vtx_bus.valid    <= 1'b1;
    vtx_bus.pos_x    <= vx.px;
    vtx_bus.pos_y    <= vx.py;
    vtx_bus.pos_z    <= vx.pz;
    vtx_bus.normal_x <= vx.nx;
    vtx_bus.normal_y <= vx.ny;
    vtx_bus.normal_z <= vx.nz;
    vtx_bus.map_u    <= vx.mu;
    vtx_bus.map_v    <= vx.mv;
    do @(posedge clk); while (!vtx_bus.ready);
    pending_tex.push_back(gen_tex_coords(vx));
  endtask

  // Drop valid, let every result come out, then let the pipeline settle
  task automatic drain_pipeline();
    vtx_bus.valid <= 1'b0;
    while (pending_tex.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup phase, access phase, then an idle phase on the bus
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << 3;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MODE:   cfg_mode = val[3:0];
      REG_UW:     cfg_uw   = val;
      REG_VW:     cfg_vw   = val;
      REG_UVOFS:  cfg_ofs  = val;
      REG_EYE_XY: cfg_exy  = val;
      REG_EYE_Z:  cfg_ez   = val[31:0];
      REG_SHIFT:  cfg_sh   = val[9:0];
      default: ;
    endcase
  endtask

  task automatic restore_defaults();
    write_reg(REG_UW, 64'd1 << FB);
    write_reg(REG_VW, 64'd1 << (32 + FB));
    write_reg(REG_UVOFS, '0);
    write_reg(REG_EYE_XY, '0);
    write_reg(REG_EYE_Z, 64'd1 << FB);
    write_reg(REG_SHIFT, '0);
  endtask

  // ---------------- tests ----------------

  // Map affine out of reset with the field extremes
  task automatic test_reset_map();
    vertex_t vx;
    vx = '0;
    send_vertex(vx);
    vx = '1;
    send_vertex(vx);
    vx = {8{32'h8000_0000}};
    send_vertex(vx);
    vx = {8{32'h7fff_ffff}};
    send_vertex(vx);
  endtask

  // Every mode code once, including the unused ones
  task automatic test_all_modes();
    vertex_t vx;
    drain_pipeline();
    write_reg(REG_SHIFT, 64'h3ff);
    write_reg(REG_UVOFS, 64'h0001_0000_ffff_0000);
    for (int m = 0; m < 16; m++) begin
      drain_pipeline();
      write_reg(REG_MODE, 64'(m));
      vx = pick_vertex();
      send_vertex(vx);
    end
  endtask

  // Zero reflection vector and an eye sitting on the vertex
  task automatic test_degenerate_eye();
    vertex_t vx;
    drain_pipeline();
    write_reg(REG_MODE, 64'(MODE_ENV_INF));
    write_reg(REG_EYE_XY, '0);
    write_reg(REG_EYE_Z, '0);
    vx = pick_vertex();
    vx.nx = '0; vx.ny = '0; vx.nz = '0;
    send_vertex(vx);
    drain_pipeline();
    write_reg(REG_MODE, 64'(MODE_ENV_LOCAL));
    write_reg(REG_EYE_XY, 64'h0003_0000_fffe_0000);
    write_reg(REG_EYE_Z, 64'h0000_0000_0005_8000);
    vx = pick_vertex();
    vx.px = 32'hfffe_0000; vx.py = 32'h0003_0000; vx.pz = 32'h0005_8000;
    send_vertex(vx);
  endtask

  // Extreme weights and offsets so that sums can wrap
  task automatic test_wrap_extremes();
    drain_pipeline();
    write_reg(REG_MODE, 64'(MODE_GEOM_Z));
    write_reg(REG_UW, 64'h8000_0000_7fff_ffff);
    write_reg(REG_VW, 64'h7fff_ffff_8000_0000);
    write_reg(REG_UVOFS, 64'h7fff_ffff_8000_0000);
    repeat (3) send_vertex(pick_vertex());
    drain_pipeline();
    write_reg(REG_MODE, 64'(MODE_SCALE_OFS));
    repeat (2) send_vertex(pick_vertex());
    drain_pipeline();
    restore_defaults();
  endtask

  // Receiver holds off for a long stretch while vertices keep coming
  task automatic test_backpressure();
    drain_pipeline();
    write_reg(REG_MODE, 64'(MODE_ENV_LOCAL));
    write_reg(REG_EYE_XY, pick_reg64());
    steady_send = 1'b1;
    hold_token <= hold_token + 1;
    repeat (250) send_vertex(pick_vertex());
    steady_send = 1'b0;
  endtask

  // Random configurations, each followed by a burst of random vertices
  task automatic test_random_phases();
    int n;
    for (int p = 0; p < 12; p++) begin
      drain_pipeline();
      if ($urandom_range(0, 5) == 0) write_reg(REG_MODE, 64'($urandom_range(10, 15)));
      else write_reg(REG_MODE, 64'($urandom_range(0, 9)));
      write_reg(REG_UW, pick_reg64());
      write_reg(REG_VW, pick_reg64());
      write_reg(REG_UVOFS, pick_reg64());
      write_reg(REG_EYE_XY, pick_reg64());
      write_reg(REG_EYE_Z, {32'd0, pick_word()});
      write_reg(REG_SHIFT, 64'($urandom_range(0, 1023)));
      steady_send = ($urandom_range(0, 3) == 0);
      steady_recv = ($urandom_range(0, 3) == 0);
      n = $urandom_range(60, 100);
      repeat (n) send_vertex(pick_vertex());
    end
    steady_send = 1'b0;
    steady_recv = 1'b0;
  endtask

  // ---------------- result side ----------------

  // Check each transaction, then decide ready for the next cycle
  always @(posedge clk) begin
    tex_pair_t want;
    if (!rst) begin
      if (tex_bus.valid && tex_bus.ready) begin
        if (pending_tex.size() == 0) begin
          $error("unexpected result: tex_u %h tex_v %h", tex_bus.tex_u, tex_bus.tex_v);
          error_count++;
        end else begin
          want = pending_tex.pop_front();
          if (tex_bus.tex_u !== want.u) begin
            $error("tex_u: expected %h, got %h", want.u, tex_bus.tex_u);
            error_count++;
          end
          if (tex_bus.tex_v !== want.v) begin
            $error("tex_v: expected %h, got %h", want.v, tex_bus.tex_v);
            error_count++;
          end
        end
      end
      if (hold_token != hold_seen) begin
        hold_seen <= hold_token;
        hold_left <= HOLD_CYCLES;
        tex_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        tex_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        tex_bus.ready <= 1'b0;
      end else if (!steady_recv && $urandom_range(0, 4) == 0) begin
        stall_left <= pick_gap();
        tex_bus.ready <= 1'b0;
      end else begin
        tex_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles in which no transaction happens on either side
  always @(posedge clk) begin
    if ((vtx_bus.valid && vtx_bus.ready) || (tex_bus.valid && tex_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("texture_coordinate_generator_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_map();
    test_all_modes();
    test_degenerate_eye();
    test_wrap_extremes();
    test_backpressure();
    test_random_phases();
    drain_pipeline();
    if (error_count == 0) begin
      $display("texture_coordinate_generator_top: match");
    end else begin
      $display("texture_coordinate_generator_top: mismatch");
    end
    $finish;
  end

endmodule

// File: texture_coordinate_generator_top.f
sv/tcg_pkg.sv
sv/tcg_in_if.sv
sv/tcg_out_if.sv
sv/tcg_core.sv
sv/texture_coordinate_generator_top.sv
test/tb_top.sv
